// ===== hdl/i2c_master_byte_engine_top_assert.svh =====
// Assertion macros used by the I2C master byte engine RTL.
`ifndef I2C_MASTER_BYTE_ENGINE_TOP_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define I2CM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2cm assertion failed");
`define I2CM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2cm assertion failed");
`else
`define I2CM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define I2CM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/i2cm_pkg.sv =====
// Types, codes and line-drive function of the I2C master byte engine.
package i2cm_pkg;

   localparam int TIMER_WIDTH_DEFAULT = 16;
   localparam int CSR_W = 16;
   localparam logic [CSR_W-1:0] PHASE_TICKS_RESET = 16'd5;

   // Item modes, also used as the active command code (tick doubles as idle)
   localparam logic [2:0] MODE_TICK  = 3'd0;
   localparam logic [2:0] MODE_START = 3'd1;
   localparam logic [2:0] MODE_STOP  = 3'd2;
   localparam logic [2:0] MODE_WRITE = 3'd3;
   localparam logic [2:0] MODE_READ  = 3'd4;
   localparam logic [2:0] CMD_IDLE   = MODE_TICK;

   // Phases within one bit slot
   localparam logic [1:0] STEP_LOW0 = 2'd0;
   localparam logic [1:0] STEP_HIGH = 2'd1;
   localparam logic [1:0] STEP_LOW1 = 2'd2;

   localparam logic [3:0] DATA_BITS  = 4'd8;
   localparam logic [3:0] BYTE_SLOTS = 4'd9;
   localparam logic [3:0] ONE_SLOT   = 4'd1;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] tx_byte;
      logic       send_nack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       slave_nack;
      logic       cmd_rejected;
   } rsp_type;

   // Line levels {scl, sda} for a command in a given phase
   function automatic logic [1:0] drive_lines(input logic [2:0] cmd, input logic [1:0] step,
                                               input logic [3:0] bitcnt, input logic out_msb,
                                               input logic ack);
      logic scl;
      logic sda;
      scl = 1'b1;
      sda = 1'b1;
      unique case (cmd)
         MODE_START: begin
            scl = (step != STEP_LOW1);
            sda = (step == STEP_LOW0);
         end
         MODE_STOP: begin
            scl = (step != STEP_LOW0);
            sda = (step == STEP_LOW1);
         end
         MODE_WRITE: begin
            scl = (step == STEP_HIGH);
            sda = (bitcnt < DATA_BITS) ? out_msb : 1'b1;
         end
         MODE_READ: begin
            scl = (step == STEP_HIGH);
            sda = (bitcnt < DATA_BITS) ? 1'b1 : ack;
         end
         default: begin
            scl = 1'b1;
            sda = 1'b1;
         end
      endcase
      return {scl, sda};
   endfunction

endpackage

// ===== hdl/i2cm_engine.sv =====
// Bus state, phase timer and next-state logic of the I2C master byte engine.
`include "i2c_master_byte_engine_top_assert.svh"
module i2cm_engine #(
   parameter int TIMER_WIDTH = i2cm_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  i2cm_pkg::req_type            item,
   input  logic                         csr_wr_en,
   input  logic [i2cm_pkg::CSR_W-1:0]   csr_wr_data,
   output i2cm_pkg::rsp_type            rsp
);

   localparam int CMP_W =
      ((TIMER_WIDTH > i2cm_pkg::CSR_W) ? TIMER_WIDTH : i2cm_pkg::CSR_W) + 1;

   logic [i2cm_pkg::CSR_W-1:0] phase_ticks_ff;
   logic [TIMER_WIDTH-1:0]     timer_ff, timer_in;
   logic [1:0]                 step_ff, step_in;
   logic [3:0]                 bit_ff, bit_in;
   logic [2:0]                 cmd_ff, cmd_in;
   logic [7:0]                 sout_ff, sout_in;
   logic [7:0]                 sin_ff, sin_in;
   logic                       ack_ff, ack_in;
   logic [1:0]                 lines_ff, lines_in;
   logic                       nack_ff, nack_in;

   logic [CMP_W-1:0] plen;
   logic [CMP_W-1:0] cap;
   logic [CMP_W-1:0] tnext;
   logic [3:0]       bit_next;
   logic [3:0]       slots;
   logic             done;
   logic             rejected;
   logic             upd;

   always_comb begin
      cap  = CMP_W'({1'b1, {TIMER_WIDTH{1'b0}}});
      plen = (phase_ticks_ff == '0) ? CMP_W'(1) : CMP_W'(phase_ticks_ff);
      if (plen > cap) begin
         plen = cap;
      end
      tnext    = CMP_W'(timer_ff) + CMP_W'(1);
      bit_next = bit_ff + 4'd1;
      slots    = ((cmd_ff == i2cm_pkg::MODE_WRITE) || (cmd_ff == i2cm_pkg::MODE_READ)) ?
                 i2cm_pkg::BYTE_SLOTS : i2cm_pkg::ONE_SLOT;

      timer_in = timer_ff;
      step_in  = step_ff;
      bit_in   = bit_ff;
      cmd_in   = cmd_ff;
      sout_in  = sout_ff;
      sin_in   = sin_ff;
      ack_in   = ack_ff;
      nack_in  = nack_ff;
      lines_in = lines_ff;
      done     = 1'b0;
      rejected = 1'b0;
      upd      = 1'b0;

      if (item.mode == i2cm_pkg::MODE_TICK) begin
         if (cmd_ff != i2cm_pkg::CMD_IDLE) begin
            if (tnext >= plen) begin
               timer_in = '0;
               // sample SDA at the end of the SCL-high phase
               if (step_ff == i2cm_pkg::STEP_HIGH) begin
                  if ((cmd_ff == i2cm_pkg::MODE_WRITE) && (bit_ff == i2cm_pkg::DATA_BITS)) begin
                     nack_in = item.sda_in;
                  end else if ((cmd_ff == i2cm_pkg::MODE_READ) &&
                               (bit_ff < i2cm_pkg::DATA_BITS)) begin
                     sin_in = {sin_ff[6:0], item.sda_in};
                  end
               end
               if (step_ff != i2cm_pkg::STEP_LOW1) begin
                  step_in = step_ff + 2'd1;
                  upd     = 1'b1;
               end else begin
                  step_in = i2cm_pkg::STEP_LOW0;
                  if (cmd_ff == i2cm_pkg::MODE_WRITE) begin
                     sout_in = {sout_ff[6:0], 1'b0};
                  end
                  if (bit_next >= slots) begin
                     cmd_in = i2cm_pkg::CMD_IDLE;
                     bit_in = '0;
                     done   = 1'b1;
                  end else begin
                     bit_in = bit_next;
                     upd    = 1'b1;
                  end
               end
            end else begin
               timer_in = tnext[TIMER_WIDTH-1:0];
            end
         end
      end else if (item.mode <= i2cm_pkg::MODE_READ) begin
         if (cmd_ff != i2cm_pkg::CMD_IDLE) begin
            rejected = 1'b1;
         end else begin
            cmd_in   = item.mode;
            timer_in = '0;
            step_in  = i2cm_pkg::STEP_LOW0;
            bit_in   = '0;
            upd      = 1'b1;
            if (item.mode == i2cm_pkg::MODE_WRITE) begin
               sout_in = item.tx_byte;
               nack_in = 1'b0;
            end else if (item.mode == i2cm_pkg::MODE_READ) begin
               sin_in = '0;
               ack_in = item.send_nack;
            end
         end
      end

      if (upd) begin
         lines_in = i2cm_pkg::drive_lines(cmd_in, step_in, bit_in, sout_in[7], ack_in);
      end

      rsp.scl_release  = lines_in[1];
      rsp.sda_release  = lines_in[0];
      rsp.busy_res     = (cmd_in != i2cm_pkg::CMD_IDLE);
      rsp.done_res     = done;
      rsp.rx_byte      = sin_in;
      rsp.slave_nack   = nack_in;
      rsp.cmd_rejected = rejected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cm_pkg::PHASE_TICKS_RESET;
         timer_ff       <= '0;
         step_ff        <= i2cm_pkg::STEP_LOW0;
         bit_ff         <= '0;
         cmd_ff         <= i2cm_pkg::CMD_IDLE;
         sout_ff        <= '0;
         sin_ff         <= '0;
         ack_ff         <= 1'b0;
         lines_ff       <= 2'b11;
         nack_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            phase_ticks_ff <= csr_wr_data;
         end
         if (advance) begin
            timer_ff <= timer_in;
            step_ff  <= step_in;
            bit_ff   <= bit_in;
            cmd_ff   <= cmd_in;
            sout_ff  <= sout_in;
            sin_ff   <= sin_in;
            ack_ff   <= ack_in;
            lines_ff <= lines_in;
            nack_ff  <= nack_in;
         end
      end
   end

   // idle engine holds a cleared phase position
   `I2CM_ASSERT_IMP(a_idle_clear, clock, reset, cmd_ff == i2cm_pkg::CMD_IDLE,
                    (step_ff == i2cm_pkg::STEP_LOW0) && (bit_ff == '0) && (timer_ff == '0))
   // bit index never runs past the acknowledge slot
   `I2CM_ASSERT_IMP(a_bit_range, clock, reset, 1'b1,
                    (bit_ff <= i2cm_pkg::DATA_BITS) && (step_ff != 2'd3))
   // data transfer: SDA holds while SCL stays high
   `I2CM_ASSERT_IMP(a_sda_stable, clock, reset,
                    ((cmd_ff == i2cm_pkg::MODE_WRITE) || (cmd_ff == i2cm_pkg::MODE_READ)) &&
                    lines_ff[1] && $past(lines_ff[1]) && !$past(reset),
                    lines_ff[0] == $past(lines_ff[0]))

endmodule

// ===== hdl/i2c_master_byte_engine_top.sv =====
// Top level of the I2C master byte engine: handshake stages around the bus engine.
// An item passes the input stage, then the result stage, before its result is offered.
// Throughput: one item per clock unless a held result stalls; the result reloads as taken.
// Per-item work is one pass of the engine's next-state logic between the two stages.
// Reset is synchronous, active high: both stages empty, engine idle, lines released,
// phase_ticks back to 5.
module i2c_master_byte_engine_top #(
   parameter int TIMER_WIDTH = i2cm_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  i2cm_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output i2cm_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [i2cm_pkg::CSR_W-1:0]  csr_wr_data
);

   // Input stage: holds one accepted item until the engine consumes it
   logic              in_valid_ff, in_valid_in;
   i2cm_pkg::req_type in_data_ff;

   // Result stage: holds the finished item until the consumer takes it
   logic              rsp_valid_ff, rsp_valid_in;
   i2cm_pkg::rsp_type rsp_data_ff;

   i2cm_pkg::rsp_type eng_rsp;
   logic              load;
   logic              req_take;

   // advance the engine when an item waits and the result slot is empty or frees up this cycle
   assign load      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || load;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: capture only, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (load) begin
         rsp_data_ff <= eng_rsp;
      end
   end

   // engine state commits only on load, so each item is applied exactly once
   i2cm_engine #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .advance     (load),
      .item        (in_data_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp         (eng_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/i2c_master_byte_engine_top_tb.sv =====
// Self-checking testbench for the I2C master byte engine top level.
`timescale 1ns / 100ps

module i2c_master_byte_engine_top_tb;
   import i2cm_pkg::*;

   // Result trails its item by two register stages.
   localparam int LATENCY      = 2;
   localparam int RANDOM_ITEMS = 1950;
   localparam int HOLD_AT      = 500;
   localparam int HOLD_CYCLES  = 300;
   localparam int SDA_LOW      = 0;
   localparam int SDA_HIGH     = 1;
   localparam int SDA_RANDOM   = 2;

   // Track the engine state per accepted item and keep the results it must produce.
   class bus_line_scoreboard;
      logic [CSR_W-1:0] phase_ticks;
      logic [15:0]      timer;
      logic [1:0]       step;
      logic [3:0]       bitcnt;
      logic [2:0]       cmd;
      logic [7:0]       shift_out;
      logic [7:0]       shift_in;
      logic             ack_level;
      logic             scl;
      logic             sda;
      logic             nack;
      rsp_type          expected_lines[$];
      int               errors;

      function new();
         phase_ticks = PHASE_TICKS_RESET;
         timer       = '0;
         step        = STEP_LOW0;
         bitcnt      = '0;
         cmd         = CMD_IDLE;
         shift_out   = '0;
         shift_in    = '0;
         ack_level   = 1'b0;
         scl         = 1'b1;
         sda         = 1'b1;
         nack        = 1'b0;
         errors      = 0;
      endfunction

      function bit busy();
         return cmd != CMD_IDLE;
      endfunction

      function int pending();
         return expected_lines.size();
      endfunction

      function void set_lines();
         case (cmd)
            MODE_START: {scl, sda} = {step != STEP_LOW1, step == STEP_LOW0};
            MODE_STOP:  {scl, sda} = {step != STEP_LOW0, step == STEP_LOW1};
            MODE_WRITE: begin
               scl = (step == STEP_HIGH);
               sda = (bitcnt < DATA_BITS) ? shift_out[7] : 1'b1;
            end
            MODE_READ: begin
               scl = (step == STEP_HIGH);
               sda = (bitcnt < DATA_BITS) ? 1'b1 : ack_level;
            end
            default: ;
         endcase
      endfunction

      // End the current phase; return 1 when the command completes.
      function bit close_phase(logic sda_level);
         logic [3:0] slots;
         if (step == STEP_HIGH) begin
            if (cmd == MODE_WRITE && bitcnt == DATA_BITS)
               nack = sda_level;
            else if (cmd == MODE_READ && bitcnt < DATA_BITS)
               shift_in = {shift_in[6:0], sda_level};
         end
         if (step != STEP_LOW1) begin
            step = step + 2'd1;
            set_lines();
            return 1'b0;
         end
         step = STEP_LOW0;
         if (cmd == MODE_WRITE)
            shift_out = {shift_out[6:0], 1'b0};
         bitcnt = bitcnt + 4'd1;
         slots = (cmd == MODE_WRITE || cmd == MODE_READ) ? BYTE_SLOTS : ONE_SLOT;
         if (bitcnt >= slots) begin
            cmd    = CMD_IDLE;
            bitcnt = '0;
            return 1'b1;
         end
         set_lines();
         return 1'b0;
      endfunction

      function rsp_type step_engine(req_type it);
         rsp_type     r;
         logic [16:0] len;
         logic [16:0] next_count;
         logic        done;
         logic        rejected;
         done     = 1'b0;
         rejected = 1'b0;
         len      = (phase_ticks == '0) ? 17'd1 : {1'b0, phase_ticks};
         if (it.mode == MODE_TICK) begin
            if (cmd != CMD_IDLE) begin
               next_count = {1'b0, timer} + 17'd1;
               if (next_count >= len) begin
                  timer = '0;
                  done  = close_phase(it.sda_in);
               end else begin
                  timer = next_count[15:0];
               end
            end
         end else if (it.mode <= MODE_READ) begin
            if (cmd != CMD_IDLE) begin
               rejected = 1'b1;
            end else begin
               cmd    = it.mode;
               timer  = '0;
               step   = STEP_LOW0;
               bitcnt = '0;
               if (it.mode == MODE_WRITE) begin
                  shift_out = it.tx_byte;
                  nack      = 1'b0;
               end else if (it.mode == MODE_READ) begin
                  shift_in  = '0;
                  ack_level = it.send_nack;
               end
               set_lines();
            end
         end
         r.scl_release  = scl;
         r.sda_release  = sda;
         r.busy_res     = (cmd != CMD_IDLE);
         r.done_res     = done;
         r.rx_byte      = shift_in;
         r.slave_nack   = nack;
         r.cmd_rejected = rejected;
         return r;
      endfunction

      function void note_item(req_type it);
         expected_lines.push_back(step_engine(it));
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_item(rsp_type got);
         rsp_type want;
         if (expected_lines.size() == 0) begin
            $error("result arrived with no item waiting for it");
            errors++;
            return;
         end
         want = expected_lines.pop_front();
         check_field("scl_release", 8'(want.scl_release), 8'(got.scl_release));
         check_field("sda_release", 8'(want.sda_release), 8'(got.sda_release));
         check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
         check_field("done_res", 8'(want.done_res), 8'(got.done_res));
         check_field("rx_byte", want.rx_byte, got.rx_byte);
         check_field("slave_nack", 8'(want.slave_nack), 8'(got.slave_nack));
         check_field("cmd_rejected", 8'(want.cmd_rejected), 8'(got.cmd_rejected));
      endfunction
   endclass

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_type          req_data    = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = '0;

   bus_line_scoreboard sb = new();

   int burst_left   = 0;
   int useful_items = 0;
   int rsp_taken    = 0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;
   bit fast_run     = 1'b0;
   int rx_cycle     = 0;

   i2c_master_byte_engine_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #24_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Result side: check every taken item, then pick ready for the next edge.
   // The stall style rotates through four patterns so stalls land on every phase;
   // one long hold-off lets the two stages fill and back up the input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_item(rsp_data);
            rsp_taken++;
         end
         rx_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_taken >= HOLD_AT && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (fast_run) begin
            rsp_ready <= 1'b1;
         end else begin
            case ((rx_cycle >> 7) % 4)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ((rx_cycle % 5) < 2);
            endcase
         end
      end
   end

   function automatic req_type make_item(logic [2:0] mode, logic [7:0] tx, logic nk,
                                         logic sda_level);
      req_type it;
      it.mode      = mode;
      it.tx_byte   = tx;
      it.send_nack = nk;
      it.sda_in    = sda_level;
      return it;
   endfunction

   // Offer one item in bursts with random gaps; hold it until it is taken.
   task automatic send_item(input req_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (fast_run || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      // Idle ticks and unused modes do nothing; leave them out of the count.
      if (it.mode <= MODE_READ && !(it.mode == MODE_TICK && !sb.busy()))
         useful_items++;
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      sb.note_item(it);
   endtask

   // Tick until the engine goes idle, sprinkling in commands that must be ignored.
   task automatic finish_command(input int sda_pick, input int noise_pct);
      logic sda_level;
      while (sb.busy()) begin
         sda_level = (sda_pick == SDA_RANDOM) ? 1'($urandom_range(0, 1)) : sda_pick[0];
         if ($urandom_range(0, 99) < noise_pct)
            send_item(make_item(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom),
                                sda_level));
         else
            send_item(make_item(MODE_TICK, 8'($urandom), 1'($urandom), sda_level));
      end
   endtask

   task automatic run_command(input logic [2:0] mode, input logic [7:0] tx, input logic nk,
                              input int sda_pick, input int noise_pct);
      send_item(make_item(mode, tx, nk, 1'($urandom)));
      finish_command(sda_pick, noise_pct);
   endtask

   // Drop valid and let every result come back before touching the register.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_phase_ticks(input logic [CSR_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.phase_ticks = value;
   endtask

   // One bus transaction: start, a few bytes with optional repeated start, stop.
   task automatic run_transaction();
      int n_ops;
      n_ops = $urandom_range(1, 3);
      run_command(MODE_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 3);
      repeat (n_ops) begin
         if ($urandom_range(0, 1) == 0)
            run_command(MODE_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM, 3);
         else
            run_command(MODE_READ, 8'($urandom), 1'($urandom), SDA_RANDOM, 3);
         if ($urandom_range(0, 7) == 0)
            run_command(MODE_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 3);
      end
      run_command(MODE_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 3);
   endtask

   // Loose items of any mode, then wrap up whatever command they started.
   task automatic run_noise();
      repeat ($urandom_range(1, 4))
         send_item(make_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                             1'($urandom)));
      finish_command(SDA_RANDOM, 10);
   endtask

   initial begin
      logic [CSR_W-1:0] settings[5];
      int               target;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle tick and unused modes at reset length, then zero length.
      send_item(make_item(MODE_TICK, 8'h00, 1'b0, 1'b0));
      send_item(make_item(3'd5, 8'hFF, 1'b1, 1'b1));
      send_item(make_item(3'd6, 8'h00, 1'b0, 1'b1));
      send_item(make_item(3'd7, 8'hFF, 1'b1, 1'b0));
      write_phase_ticks('0);
      send_item(make_item(MODE_START, 8'h00, 1'b0, 1'b1));
      // Commands while busy: rejected or ignored, no time passes.
      send_item(make_item(MODE_WRITE, 8'hA5, 1'b0, 1'b0));
      send_item(make_item(MODE_READ, 8'h5A, 1'b1, 1'b1));
      send_item(make_item(3'd7, 8'hFF, 1'b1, 1'b1));
      finish_command(SDA_RANDOM, 0);
      // Slave NACK on an all-zero byte, ACK on all ones.
      run_command(MODE_WRITE, 8'h00, 1'b0, SDA_HIGH, 0);
      run_command(MODE_WRITE, 8'hFF, 1'b1, SDA_LOW, 0);
      // Reads with master ACK and master NACK, both bus levels.
      run_command(MODE_READ, 8'h00, 1'b0, SDA_HIGH, 0);
      run_command(MODE_READ, 8'hFF, 1'b1, SDA_LOW, 0);
      run_command(MODE_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);

      // Long phase: one start at full rate, no stalls.
      write_phase_ticks(16'd40);
      fast_run = 1'b1;
      run_command(MODE_START, 8'h00, 1'b0, SDA_RANDOM, 0);
      fast_run = 1'b0;

      // Random: well-formed transactions at several phase lengths, some noise.
      settings[0] = 16'd1;
      settings[1] = 16'd2;
      settings[2] = PHASE_TICKS_RESET;
      settings[3] = 16'd3;
      settings[4] = 16'($urandom_range(1, 4));
      useful_items = 0;
      foreach (settings[k]) begin
         write_phase_ticks(settings[k]);
         target = RANDOM_ITEMS * (k + 1) / 5;
         while (useful_items < target) begin
            if ($urandom_range(0, 9) < 8)
               run_transaction();
            else
               run_noise();
         end
      end

      drain();
      repeat (LATENCY + 4) @(posedge clock);
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/i2cm_pkg.sv
hdl/i2cm_engine.sv
hdl/i2c_master_byte_engine_top.sv
tb/i2c_master_byte_engine_top_tb.sv
